FILE: hw/rtl/mau_pkg.sv
// Shared types and constants for the modular arithmetic unit.
// Used by the controller, the datapath, the top level and the port checker.
package mau_pkg;

  localparam int A_W       = 32;   // operand_a width
  localparam int RES_W     = 16;   // result, operand_b and modulus width
  localparam int WIDTH_DEF = 16;
  localparam int CNT_W     = 5;    // step counter, counts up to A_W - 1
  localparam logic [RES_W-1:0] MOD_RESET = 16'd2;

  typedef enum logic [2:0] {
    OP_REDUCE = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_INV    = 3'd4,
    OP_DIV    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DIV_ZERO = 2'd1,
    STAT_NO_INV   = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_FIX_A,
    S_RED_B,
    S_FIX_B,
    S_DISPATCH,
    S_EUC_START,
    S_EUC_RUN,
    S_EUC_UPD,
    S_EUC_END,
    S_MUL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic signed [31:0] operand_a;
    logic [15:0]       operand_b;
  } in_word_t;

  typedef struct packed {
    logic [15:0] result;
    logic [1:0]  status;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch a new word, start reducing operand_a
    logic div_step;   // one restoring division step
    logic fix_a;      // settle residue of a, start reducing b
    logic fix_b;      // settle residue of b, set up Euclid
    logic euc_start;  // begin one Euclid quotient step
    logic hor_step;   // one doubling step of the modular multiply
    logic hor_mul;    // multiply mode: bits from the shifter, addend is a
    logic euc_upd;    // rotate remainders and coefficients
    logic mul_start;  // begin the modular multiply
    logic load_out;   // capture the result word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       rb_zero;
    logic       rem_zero;
    logic       gcd_one;
  } sts_t;

endpackage

FILE: hw/rtl/mau_ctrl.sv
// Sequencer for the modular arithmetic unit: handshakes and step counting.
// Depends on mau_pkg; drives the datapath through mau_pkg::cmd_t.
module mau_ctrl #(
  parameter int WIDTH = mau_pkg::WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mau_pkg::sts_t sts,
  output mau_pkg::cmd_t cmd
);

  localparam int W     = (WIDTH < mau_pkg::RES_W) ? WIDTH : mau_pkg::RES_W;
  localparam int CNT_W = mau_pkg::CNT_W;

  mau_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mau_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      mau_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = mau_pkg::S_RED_A;
        end
      end
      mau_pkg::S_RED_A: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(mau_pkg::A_W - 1)) begin
          state_nxt = mau_pkg::S_FIX_A;
        end
      end
      mau_pkg::S_FIX_A: begin
        cmd.fix_a = 1'b1;
        cnt_nxt   = '0;
        state_nxt = mau_pkg::S_RED_B;
      end
      mau_pkg::S_RED_B: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          state_nxt = mau_pkg::S_FIX_B;
        end
      end
      mau_pkg::S_FIX_B: begin
        cmd.fix_b = 1'b1;
        state_nxt = mau_pkg::S_DISPATCH;
      end
      mau_pkg::S_DISPATCH: begin
        cnt_nxt = '0;
        if (sts.op == mau_pkg::OP_MUL) begin
          cmd.mul_start = 1'b1;
          state_nxt     = mau_pkg::S_MUL;
        end else if ((sts.op inside {mau_pkg::OP_INV, mau_pkg::OP_DIV}) && !sts.rb_zero) begin
          cmd.euc_start = 1'b1;
          state_nxt     = mau_pkg::S_EUC_RUN;
        end else begin
          state_nxt = mau_pkg::S_FINISH;
        end
      end
      mau_pkg::S_EUC_START: begin
        cmd.euc_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = mau_pkg::S_EUC_RUN;
      end
      mau_pkg::S_EUC_RUN: begin
        // multiply uses the registered quotient bit and trails the divider: one extra step at the end
        cmd.hor_step = 1'b1;
        if (cnt_r != CNT_W'(W)) begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          state_nxt = mau_pkg::S_EUC_UPD;
        end
      end
      mau_pkg::S_EUC_UPD: begin
        cmd.euc_upd = 1'b1;
        state_nxt   = sts.rem_zero ? mau_pkg::S_EUC_END : mau_pkg::S_EUC_START;
      end
      mau_pkg::S_EUC_END: begin
        cnt_nxt = '0;
        if (sts.op == mau_pkg::OP_DIV && sts.gcd_one) begin
          cmd.mul_start = 1'b1;
          state_nxt     = mau_pkg::S_MUL;
        end else begin
          state_nxt = mau_pkg::S_FINISH;
        end
      end
      mau_pkg::S_MUL: begin
        cmd.hor_step = 1'b1;
        cmd.hor_mul  = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          state_nxt = mau_pkg::S_FINISH;
        end
      end
      mau_pkg::S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mau_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mau_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != mau_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/mau_datapath.sv
// Datapath of the modular arithmetic unit: restoring divider, doubling
// modular multiplier, Euclid registers and the result register.
// Depends on mau_pkg; commanded by mau_ctrl.
module mau_datapath #(
  parameter int WIDTH = mau_pkg::WIDTH_DEF
) (
  input  logic                clk,
  input  mau_pkg::in_word_t   in_word,
  input  logic [((WIDTH < mau_pkg::RES_W) ? WIDTH : mau_pkg::RES_W)-1:0] modulus,
  input  mau_pkg::cmd_t       cmd,
  output mau_pkg::sts_t       sts,
  output mau_pkg::out_word_t  out_word
);

  localparam int W   = (WIDTH < mau_pkg::RES_W) ? WIDTH : mau_pkg::RES_W;
  localparam int W1  = W + 1;
  localparam int AW  = mau_pkg::A_W;
  localparam int RW  = mau_pkg::RES_W;
  localparam int PAD = AW - W;

  logic [2:0]    op_r, op_nxt;
  logic          neg_r, neg_nxt;
  logic [AW-1:0] sh_r, sh_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  div_r, div_nxt;
  logic          qbit_r, qbit_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  ra_r, ra_nxt;
  logic [W-1:0]  rb_r, rb_nxt;
  logic [W-1:0]  r0_r, r0_nxt;
  logic [W-1:0]  r1_r, r1_nxt;
  logic [W-1:0]  t0_r, t0_nxt;
  logic [W-1:0]  t1_r, t1_nxt;
  mau_pkg::out_word_t res_r, res_nxt;

  logic [AW-1:0] a_mag;
  logic [W1-1:0] trial, mod_x;
  logic          ge;
  logic [W-1:0]  rem_step;
  logic [W1-1:0] dbl, sum;
  logic [W-1:0]  dbl_red, addend, acc_step;
  logic          hor_bit;
  logic [W1-1:0] add_s;
  logic [W-1:0]  add_res, sub_res, t_sub;

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    neg_r  <= neg_nxt;
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    qbit_r <= qbit_nxt;
    acc_r  <= acc_nxt;
    b_r    <= b_nxt;
    ra_r   <= ra_nxt;
    rb_r   <= rb_nxt;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    res_r  <= res_nxt;
  end

  assign mod_x = {1'b0, modulus};
  assign a_mag = in_word.operand_a[AW-1] ? (~in_word.operand_a + 1'b1) : in_word.operand_a;

  // restoring division step, dividend bits enter from the top of the shifter
  assign trial    = {rem_r, sh_r[AW-1]};
  assign ge       = (trial >= {1'b0, div_r});
  assign rem_step = ge ? W'(trial - {1'b0, div_r}) : trial[W-1:0];

  // acc = 2*acc + bit*addend, all mod m
  assign hor_bit  = cmd.hor_mul ? sh_r[AW-1] : qbit_r;
  assign addend   = cmd.hor_mul ? ra_r : t1_r;
  assign dbl      = {acc_r, 1'b0};
  assign dbl_red  = (dbl >= mod_x) ? W'(dbl - mod_x) : dbl[W-1:0];
  assign sum      = {1'b0, dbl_red} + (hor_bit ? {1'b0, addend} : '0);
  assign acc_step = (sum >= mod_x) ? W'(sum - mod_x) : sum[W-1:0];

  assign add_s   = {1'b0, ra_r} + {1'b0, rb_r};
  assign add_res = (add_s >= mod_x) ? W'(add_s - mod_x) : add_s[W-1:0];
  assign sub_res = (ra_r >= rb_r) ? (ra_r - rb_r) : W'(mod_x + {1'b0, ra_r} - {1'b0, rb_r});
  assign t_sub   = (t0_r >= acc_r) ? (t0_r - acc_r)
                                   : W'(mod_x + {1'b0, t0_r} - {1'b0, acc_r});

  always_comb begin
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    qbit_nxt = qbit_r;
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    r0_nxt   = r0_r;
    r1_nxt   = r1_r;
    t0_nxt   = t0_r;
    t1_nxt   = t1_r;
    res_nxt  = res_r;

    if (cmd.load) begin
      op_nxt  = in_word.operation;
      neg_nxt = in_word.operand_a[AW-1];
      sh_nxt  = a_mag;
      rem_nxt = '0;
      div_nxt = modulus;
      b_nxt   = in_word.operand_b[W-1:0];
    end
    if (cmd.div_step) begin
      rem_nxt  = rem_step;
      qbit_nxt = ge;
      sh_nxt   = {sh_r[AW-2:0], 1'b0};
    end
    if (cmd.hor_step) begin
      acc_nxt = acc_step;
      if (cmd.hor_mul) begin
        sh_nxt = {sh_r[AW-2:0], 1'b0};
      end
    end
    if (cmd.fix_a) begin
      // a negative value with a nonzero residue folds to m - residue
      ra_nxt  = (neg_r && rem_r != '0) ? (modulus - rem_r) : rem_r;
      sh_nxt  = {b_r, {PAD{1'b0}}};
      rem_nxt = '0;
    end
    if (cmd.fix_b) begin
      rb_nxt = rem_r;
      r0_nxt = modulus;
      r1_nxt = rem_r;
      t0_nxt = '0;
      t1_nxt = W'(1);
    end
    if (cmd.euc_start) begin
      sh_nxt   = {r0_r, {PAD{1'b0}}};
      rem_nxt  = '0;
      div_nxt  = r1_r;
      acc_nxt  = '0;
      qbit_nxt = 1'b0;
    end
    if (cmd.euc_upd) begin
      r0_nxt = r1_r;
      r1_nxt = rem_r;
      t0_nxt = t1_r;
      t1_nxt = t_sub;
    end
    if (cmd.mul_start) begin
      sh_nxt  = {((op_r == mau_pkg::OP_MUL) ? rb_r : t0_r), {PAD{1'b0}}};
      acc_nxt = '0;
    end
    if (cmd.load_out) begin
      res_nxt.result = '0;
      res_nxt.status = mau_pkg::STAT_OK;
      case (op_r)
        mau_pkg::OP_REDUCE: res_nxt.result = RW'(ra_r);
        mau_pkg::OP_ADD:    res_nxt.result = RW'(add_res);
        mau_pkg::OP_SUB:    res_nxt.result = RW'(sub_res);
        mau_pkg::OP_MUL:    res_nxt.result = RW'(acc_r);
        mau_pkg::OP_INV, mau_pkg::OP_DIV: begin
          if (rb_r == '0) begin
            res_nxt.status = mau_pkg::STAT_DIV_ZERO;
          end else if (r0_r != W'(1)) begin
            res_nxt.status = mau_pkg::STAT_NO_INV;
          end else begin
            res_nxt.result = (op_r == mau_pkg::OP_INV) ? RW'(t0_r) : RW'(acc_r);
          end
        end
        default: res_nxt.result = '0;
      endcase
    end
  end

  assign sts.op       = op_r;
  assign sts.rb_zero  = (rb_r == '0);
  assign sts.rem_zero = (rem_r == '0);
  assign sts.gcd_one  = (r0_r == W'(1));
  assign out_word     = res_r;

endmodule

FILE: hw/rtl/modular_arithmetic_unit.sv
// Modular arithmetic unit: reduce, add, subtract, multiply, inverse, divide mod m.
// One word at a time; the next is taken once the result is registered.
// Sequence, W = min(WIDTH,16): a and b are reduced mod m by the shared bit-serial
// divider; multiply then runs the doubling multiplier; inverse and divide run
// extended Euclid steps, each a division with the multiplier alongside, and divide
// then multiplies when an inverse exists. Synchronous active-low reset clears the
// sequencer, the output valid and sets modulus to 2.
module modular_arithmetic_unit #(
  parameter int WIDTH = mau_pkg::WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mau_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output mau_pkg::out_word_t out_word,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  localparam int W = (WIDTH < mau_pkg::RES_W) ? WIDTH : mau_pkg::RES_W;
  localparam logic [W-1:0] MOD_MIN = W'(2);

  logic [15:0]   modulus_r, modulus_nxt;
  logic [W-1:0]  mod_masked, mod_live;
  mau_pkg::cmd_t cmd;
  mau_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mau_pkg::MOD_RESET;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  assign modulus_nxt = cfg_wr_en ? cfg_wr_data : modulus_r;
  assign mod_masked  = modulus_r[W-1:0];
  // a modulus of 0 or 1 behaves as 2
  assign mod_live    = (mod_masked < MOD_MIN) ? MOD_MIN : mod_masked;

  mau_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk      (clk),
    .in_word  (in_word),
    .modulus  (mod_live),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

FILE: hw/rtl/mau_checker.sv
// Port-level checks for the modular arithmetic unit, bound to the top level.
// Depends on mau_pkg and on the port names of modular_arithmetic_unit.
module mau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input mau_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input mau_pkg::out_word_t out_word
);

  // one word in flight: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word was in flight");

  // error results carry a zero residue
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != mau_pkg::STAT_OK |-> out_word.result == 16'd0)
    else $error("error status with nonzero result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("output word changed while stalled");

  // input payload is the sender's to hold; referenced so the operation field is checked for X on accept
  a_in_op_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !$isunknown(in_word.operation))
    else $error("unknown operation on accepted word");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (.*);
